// ----- rtl/vsa_pkg.sv -----
`default_nettype none

package vsa_pkg;

   localparam int MAX_VOICES_DEF = 32;

   localparam int NOTE_W        = 7;
   localparam int OFFS_W        = 12;
   localparam int AGE_W         = 64;
   localparam int SLOT_FIELD_W  = 5;
   localparam int COUNT_FIELD_W = 6;
   localparam int REQ_DATA_W    = 24;
   localparam int RSP_DATA_W    = 24;

   typedef enum logic [1:0] {
      OP_LEASE  = 2'd0,
      OP_RETURN = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_FREE     = 2'd0,
      ST_ACTIVE   = 2'd1,
      ST_RETURNED = 2'd2
   } status_type;

   typedef struct packed {
      status_type          status;
      logic [NOTE_W-1:0]   note;
      logic [OFFS_W-1:0]   offset;
      logic [AGE_W-1:0]    age;
   } slot_entry_type;

   typedef enum logic [6:0] {
      S_INIT   = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_SCAN   = 7'b0000100,
      S_COMMIT = 7'b0001000,
      S_FETCH  = 7'b0010000,
      S_SWEEP  = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/voice_slot_allocator_unit.sv -----
`default_nettype none

// Channel  Dir  tdata (low bit up)                              tuser
// req      in   note_number[6:0] start_offset[18:7]             opcode[1:0]
//                return_slot[23:19]
// rsp      out  granted_slot[4:0] released_note[11:5]           released_valid
//                active_voices[17:12], zero pad [23:18]
//
// Lease: one pass over the slot RAM in SCAN, then COMMIT; clear: one pass over the RAM in SWEEP.
// Return: one slot read in FETCH; opcode three and out-of-range returns go straight to FINISH.
// The scans issue one slot RAM read per cycle.
// After reset an init pass fills the RAM; req_tready stays low.
// A finished result waits in FINISH while rsp is stalled and a previous result is held.

module voice_slot_allocator_unit
   import vsa_pkg::*;
#(
   parameter int MAX_VOICES = MAX_VOICES_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire [REQ_DATA_W-1:0]    req_tdata,  // note_number, start_offset, return_slot
   input  wire [1:0]               req_tuser,  // opcode
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,  // granted_slot, released_note, active_voices
   output logic [0:0]              rsp_tuser   // released_valid
);

   localparam int IDX_W = $clog2(MAX_VOICES);
   localparam int CTR_W = $clog2(MAX_VOICES + 1);
   localparam int ENTRY_W = $bits(slot_entry_type);

   state_type state_ff, state_in;
   logic [CTR_W-1:0] issue_ff, issue_in;
   logic pend_ff, pend_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;

   logic [NOTE_W-1:0] note_ff, note_in;
   logic [OFFS_W-1:0] offs_ff, offs_in;
   logic [SLOT_FIELD_W-1:0] rslot_ff, rslot_in;

   logic free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [AGE_W-1:0] best_age_ff, best_age_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic best_active_ff, best_active_in;
   logic [NOTE_W-1:0] best_note_ff, best_note_in;

   logic [AGE_W-1:0] age_ctr_ff, age_ctr_in;
   logic [CTR_W-1:0] active_ff, active_in;

   logic [SLOT_FIELD_W-1:0] res_granted_ff, res_granted_in;
   logic [NOTE_W-1:0] res_note_ff, res_note_in;
   logic res_rel_ff, res_rel_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic rsp_user_ff, rsp_user_in;

   logic wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   slot_entry_type wr_data, rd_data;
   logic [ENTRY_W-1:0] rd_bits;

   opcode_type req_op;
   logic [NOTE_W-1:0] req_note;
   logic [OFFS_W-1:0] req_offs;
   logic [SLOT_FIELD_W-1:0] req_rslot;
   logic req_rslot_ok;
   logic [IDX_W+SLOT_FIELD_W-1:0] req_slot_ext, hold_slot_ext, lease_slot_ext;
   logic [CTR_W+COUNT_FIELD_W-1:0] active_ext;
   logic [IDX_W-1:0] lease_slot;
   logic steal;
   logic issue_go, scan_last;

   assign req_op    = opcode_type'(req_tuser);
   assign req_note  = req_tdata[NOTE_W-1:0];
   assign req_offs  = req_tdata[NOTE_W+OFFS_W-1:NOTE_W];
   assign req_rslot = req_tdata[NOTE_W+OFFS_W+SLOT_FIELD_W-1:NOTE_W+OFFS_W];
   assign req_rslot_ok = int'(req_rslot) < MAX_VOICES;

   assign req_slot_ext   = {{IDX_W{1'b0}}, req_rslot};
   assign hold_slot_ext  = {{IDX_W{1'b0}}, rslot_ff};
   assign lease_slot     = free_found_ff ? free_idx_ff : best_idx_ff;
   assign lease_slot_ext = {{SLOT_FIELD_W{1'b0}}, lease_slot};
   assign active_ext     = {{COUNT_FIELD_W{1'b0}}, active_ff};
   assign steal          = !free_found_ff && best_active_ff;

   assign issue_go  = issue_ff < CTR_W'(MAX_VOICES);
   assign scan_last = pend_ff && (issue_ff == CTR_W'(MAX_VOICES));

   assign rd_data = slot_entry_type'(rd_bits);

   vsa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_VOICES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   always_comb begin
      state_in       = state_ff;
      issue_in       = issue_ff;
      pend_in        = pend_ff;
      pidx_in        = pidx_ff;
      note_in        = note_ff;
      offs_in        = offs_ff;
      rslot_in       = rslot_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      best_age_in    = best_age_ff;
      best_idx_in    = best_idx_ff;
      best_active_in = best_active_ff;
      best_note_in   = best_note_ff;
      age_ctr_in     = age_ctr_ff;
      active_in      = active_ff;
      res_granted_in = res_granted_ff;
      res_note_in    = res_note_ff;
      res_rel_in     = res_rel_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;
      wr_en          = 1'b0;
      wr_addr        = pidx_ff;
      wr_data        = rd_data;
      rd_en          = 1'b0;
      rd_addr        = issue_ff[IDX_W-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            wr_en   = 1'b1;
            wr_addr = issue_ff[IDX_W-1:0];
            wr_data = '{status: ST_FREE, note: '0, offset: '0, age: AGE_W'(issue_ff)};
            issue_in = issue_ff + 1'b1;
            if (issue_ff == CTR_W'(MAX_VOICES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               note_in        = req_note;
               offs_in        = req_offs;
               rslot_in       = req_rslot;
               issue_in       = '0;
               pend_in        = 1'b0;
               free_found_in  = 1'b0;
               res_granted_in = '0;
               res_note_in    = '0;
               res_rel_in     = 1'b0;
               case (req_op)
                  OP_LEASE: begin
                     state_in = S_SCAN;
                  end
                  OP_RETURN: begin
                     res_granted_in = req_rslot;
                     if (req_rslot_ok) begin
                        rd_en    = 1'b1;
                        rd_addr  = req_slot_ext[IDX_W-1:0];
                        state_in = S_FETCH;
                     end else begin
                        state_in = S_FINISH;
                     end
                  end
                  OP_CLEAR: begin
                     state_in = S_SWEEP;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_SCAN: begin
            rd_en   = issue_go;
            pend_in = issue_go;
            pidx_in = issue_ff[IDX_W-1:0];
            if (issue_go) begin
               issue_in = issue_ff + 1'b1;
            end
            if (pend_ff) begin
               if (!free_found_ff && rd_data.status == ST_FREE) begin
                  free_found_in = 1'b1;
                  free_idx_in   = pidx_ff;
               end
               if (pidx_ff == '0 || rd_data.age < best_age_ff) begin
                  best_age_in    = rd_data.age;
                  best_idx_in    = pidx_ff;
                  best_active_in = rd_data.status == ST_ACTIVE;
                  best_note_in   = rd_data.note;
               end
            end
            if (scan_last) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            age_ctr_in = age_ctr_ff + 1'b1;
            wr_en      = 1'b1;
            wr_addr    = lease_slot;
            wr_data    = '{status: ST_ACTIVE, note: note_ff, offset: offs_ff,
                           age: age_ctr_ff + 1'b1};
            if (!steal && active_ff < CTR_W'(MAX_VOICES)) begin
               active_in = active_ff + 1'b1;
            end
            res_granted_in = lease_slot_ext[SLOT_FIELD_W-1:0];
            res_note_in    = steal ? best_note_ff : '0;
            res_rel_in     = steal;
            state_in       = S_FINISH;
         end
         S_FETCH: begin
            if (rd_data.status == ST_ACTIVE) begin
               wr_en          = 1'b1;
               wr_addr        = hold_slot_ext[IDX_W-1:0];
               wr_data.status = ST_RETURNED;
               if (active_ff != '0) begin
                  active_in = active_ff - 1'b1;
               end
               res_note_in = rd_data.note;
               res_rel_in  = 1'b1;
            end
            state_in = S_FINISH;
         end
         S_SWEEP: begin
            rd_en   = issue_go;
            pend_in = issue_go;
            pidx_in = issue_ff[IDX_W-1:0];
            if (issue_go) begin
               issue_in = issue_ff + 1'b1;
            end
            if (pend_ff && rd_data.status == ST_RETURNED) begin
               wr_en          = 1'b1;
               wr_data.status = ST_FREE;
            end
            if (scan_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_DATA_W - COUNT_FIELD_W - NOTE_W - SLOT_FIELD_W){1'b0}},
                               active_ext[COUNT_FIELD_W-1:0], res_note_ff, res_granted_ff};
               rsp_user_in  = res_rel_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         issue_ff      <= '0;
         pend_ff       <= 1'b0;
         free_found_ff <= 1'b0;
         age_ctr_ff    <= AGE_W'(MAX_VOICES);
         active_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_ff      <= issue_in;
         pend_ff       <= pend_in;
         free_found_ff <= free_found_in;
         age_ctr_ff    <= age_ctr_in;
         active_ff     <= active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff        <= pidx_in;
      note_ff        <= note_in;
      offs_ff        <= offs_in;
      rslot_ff       <= rslot_in;
      free_idx_ff    <= free_idx_in;
      best_age_ff    <= best_age_in;
      best_idx_ff    <= best_idx_in;
      best_active_ff <= best_active_in;
      best_note_ff   <= best_note_in;
      res_granted_ff <= res_granted_in;
      res_note_ff    <= res_note_in;
      res_rel_ff     <= res_rel_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_user_ff    <= rsp_user_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

// ----- rtl/vsa_ram.sv -----
`default_nettype none

module vsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire [WIDTH-1:0]           wr_data,
   input  wire                       rd_en,
   input  wire [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/vsa_checker.sv -----
`default_nettype none

module vsa_checker
   import vsa_pkg::*;
#(
   parameter int MAX_VOICES = MAX_VOICES_DEF
) (
   input wire                     clock,
   input wire                     reset,
   input wire                     req_tvalid,
   input wire                     req_tready,
   input wire                     rsp_tvalid,
   input wire                     rsp_tready,
   input wire [RSP_DATA_W-1:0]    rsp_tdata,
   input wire [0:0]               rsp_tuser
);

   // init pass keeps the input closed right after reset
   a_closed_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("req_tready high right after reset");

   // one item at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high in the cycle after a transfer");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> int'(rsp_tdata[SLOT_FIELD_W+NOTE_W+COUNT_FIELD_W-1:SLOT_FIELD_W+NOTE_W])
                     <= MAX_VOICES)
      else $error("active_voices above voice count");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp transfer changed");

endmodule

bind voice_slot_allocator_unit vsa_checker #(
   .MAX_VOICES (MAX_VOICES)
) u_vsa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import vsa_pkg::*;

   localparam int VOICES       = MAX_VOICES_DEF;
   localparam int TOTAL_ITEMS  = 1420;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [SLOT_FIELD_W-1:0]  slot;
      logic [NOTE_W-1:0]        note;
      logic                     ended;
      logic [COUNT_FIELD_W-1:0] voices;
   } grant_type;

   class alloc_scoreboard_type;
      status_type        slot_state[VOICES];
      logic [NOTE_W-1:0] slot_note[VOICES];
      logic [OFFS_W-1:0] slot_offs[VOICES];
      logic [AGE_W-1:0]  slot_age[VOICES];
      logic [AGE_W-1:0]  age_ctr;
      int unsigned       voices_on;
      grant_type         expected_grants[$];
      int                errors;

      function new();
         for (int i = 0; i < VOICES; i++) begin
            slot_state[i] = ST_FREE;
            slot_note[i]  = '0;
            slot_offs[i]  = '0;
            slot_age[i]   = AGE_W'(i);
         end
         age_ctr   = AGE_W'(VOICES);
         voices_on = 0;
         errors    = 0;
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] grant mismatch: %s", $realtime, msg);
         errors++;
      endtask

      function int pick_active();
         int busy[$];
         for (int i = 0; i < VOICES; i++)
            if (slot_state[i] == ST_ACTIVE) busy.insert(busy.size(), i);
         if (busy.size() == 0) return -1;
         return busy[$urandom_range(busy.size() - 1)];
      endfunction

      // one transfer in, one expected grant out
      function void note_request(opcode_type op, logic [NOTE_W-1:0] note,
                                 logic [OFFS_W-1:0] offs, logic [SLOT_FIELD_W-1:0] rs);
         grant_type g;
         int        pick;
         bit        found;
         g     = '0;
         pick  = 0;
         found = 1'b0;
         case (op)
            OP_LEASE: begin
               for (int i = 0; i < VOICES && !found; i++)
                  if (slot_state[i] == ST_FREE) begin
                     pick  = i;
                     found = 1'b1;
                  end
               if (found) begin
                  if (voices_on < VOICES) voices_on++;
               end else begin
                  // no free slot: take the oldest, lowest index on ties
                  for (int i = 1; i < VOICES; i++)
                     if (slot_age[i] < slot_age[pick]) pick = i;
                  if (slot_state[pick] == ST_ACTIVE) begin
                     g.note  = slot_note[pick];
                     g.ended = 1'b1;
                  end else if (voices_on < VOICES) begin
                     voices_on++;
                  end
               end
               age_ctr          = age_ctr + 1'b1;
               slot_age[pick]   = age_ctr;
               slot_note[pick]  = note;
               slot_offs[pick]  = offs;
               slot_state[pick] = ST_ACTIVE;
               g.slot           = SLOT_FIELD_W'(pick);
            end
            OP_RETURN: begin
               g.slot = rs;
               if (int'(rs) < VOICES && slot_state[rs] == ST_ACTIVE) begin
                  slot_state[rs] = ST_RETURNED;
                  if (voices_on > 0) voices_on--;
                  g.note  = slot_note[rs];
                  g.ended = 1'b1;
               end
            end
            OP_CLEAR: begin
               for (int i = 0; i < VOICES; i++)
                  if (slot_state[i] == ST_RETURNED) slot_state[i] = ST_FREE;
            end
            default: ;
         endcase
         g.voices = COUNT_FIELD_W'(voices_on);
         expected_grants.insert(expected_grants.size(), g);
      endfunction

      task check_grant(grant_type got);
         grant_type want;
         if (expected_grants.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer slot %0d", got.slot));
            return;
         end
         want = expected_grants.pop_front();
         if (got.slot !== want.slot)
            report_mismatch($sformatf("granted_slot %0d, want %0d", got.slot, want.slot));
         if (got.note !== want.note)
            report_mismatch($sformatf("released_note %0d, want %0d", got.note, want.note));
         if (got.ended !== want.ended)
            report_mismatch($sformatf("released_valid %0d, want %0d", got.ended, want.ended));
         if (got.voices !== want.voices)
            report_mismatch($sformatf("active_voices %0d, want %0d", got.voices, want.voices));
      endtask
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = '0;
   logic                  rsp_tready = 1'b0;
   wire                   req_tready;
   wire                   rsp_tvalid;
   wire [RSP_DATA_W-1:0]  rsp_tdata;
   wire [0:0]             rsp_tuser;

   alloc_scoreboard_type sb;
   int                   items_sent  = 0;
   int                   cycle_count = 0;
   wire                  calm        = (items_sent >= 700) && (items_sent < 950);

   voice_slot_allocator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 12);
   end

   always @(posedge clock) begin
      grant_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.slot   = rsp_tdata[4:0];
         got.note   = rsp_tdata[11:5];
         got.ended  = rsp_tuser[0];
         got.voices = rsp_tdata[17:12];
         sb.check_grant(got);
      end
   end

   task automatic send_item(opcode_type op, logic [NOTE_W-1:0] note,
                            logic [OFFS_W-1:0] offs, logic [SLOT_FIELD_W-1:0] rs);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {rs, offs, note};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, note, offs, rs);
      items_sent++;
      if (!calm && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic random_lease();
      send_item(OP_LEASE, NOTE_W'($urandom_range(127)), OFFS_W'($urandom_range(4095)),
                SLOT_FIELD_W'($urandom_range(31)));
   endtask

   task automatic return_active();
      int s;
      s = sb.pick_active();
      if (s < 0) s = $urandom_range(31);
      send_item(OP_RETURN, NOTE_W'($urandom_range(127)), OFFS_W'($urandom_range(4095)),
                SLOT_FIELD_W'(s));
   endtask

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, ignored returns, clear, unused opcode
      send_item(OP_NONE,   7'h7f, 12'hfff, 5'h1f);
      send_item(OP_RETURN, 7'h00, 12'h000, 5'h00);
      send_item(OP_LEASE,  7'h00, 12'h000, 5'h00);
      send_item(OP_LEASE,  7'h7f, 12'hfff, 5'h1f);
      send_item(OP_LEASE,  7'h55, 12'haaa, 5'h15);
      send_item(OP_LEASE,  7'h2a, 12'h555, 5'h0a);
      send_item(OP_RETURN, 7'h7f, 12'hfff, 5'h01);
      send_item(OP_RETURN, 7'h00, 12'h000, 5'h01);
      send_item(OP_RETURN, 7'h00, 12'h000, 5'h1f);
      send_item(OP_LEASE,  7'h11, 12'h123, 5'h00);
      send_item(OP_CLEAR,  7'h7f, 12'hfff, 5'h1f);
      send_item(OP_LEASE,  7'h33, 12'h800, 5'h10);
      send_item(OP_RETURN, 7'h00, 12'h000, 5'h00);
      send_item(OP_NONE,   7'h00, 12'h000, 5'h00);
      send_item(OP_CLEAR,  7'h00, 12'h000, 5'h00);
      send_item(OP_RETURN, 7'h00, 12'h000, 5'h00);

      // random: fill and steal bursts, churn, drains, some noise
      while (items_sent < TOTAL_ITEMS) begin
         case ($urandom_range(9))
            0, 1, 2: repeat ($urandom_range(5, 40)) random_lease();
            3, 4, 5: repeat ($urandom_range(10, 30)) begin
               if ($urandom_range(1)) random_lease();
               else return_active();
            end
            6, 7: begin
               repeat ($urandom_range(3, 20)) return_active();
               if ($urandom_range(1))
                  send_item(OP_CLEAR, NOTE_W'($urandom_range(127)),
                            OFFS_W'($urandom_range(4095)), SLOT_FIELD_W'($urandom_range(31)));
            end
            8: repeat ($urandom_range(2, 8))
               send_item(opcode_type'(2'($urandom_range(3))), NOTE_W'($urandom_range(127)),
                         OFFS_W'($urandom_range(4095)), SLOT_FIELD_W'($urandom_range(31)));
            default: send_item(OP_CLEAR, NOTE_W'($urandom_range(127)),
                               OFFS_W'($urandom_range(4095)), SLOT_FIELD_W'($urandom_range(31)));
         endcase
      end
      req_tvalid <= 1'b0;

      while (sb.expected_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
